@@ hdl/amic_pkg.sv @@
// shared constants, types and codes of the motion driven ir controller
`timescale 1ns / 1ps

package amic_pkg;

  // sample and window sizing
  localparam int SAMPLE_W   = 16;
  localparam int MAX_WINDOW = 1024;
  localparam int LOG_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + LOG_W;
  localparam int AVG_W      = SAMPLE_W;
  localparam int STEP_W     = $clog2(AVG_W + 1);

  // register widths and reset values
  localparam int THR_W = 16;
  localparam int WIN_W = 11;
  localparam int LIM_W = 8;
  localparam int WCNT_W = 8;

  localparam logic [THR_W-1:0] THR_RST    = THR_W'(410);
  localparam logic [WIN_W-1:0] WIN_RST    = WIN_W'(200);
  localparam logic [LIM_W-1:0] MLIMIT_RST = LIM_W'(5);
  localparam logic [LIM_W-1:0] SLIMIT_RST = LIM_W'(60);

  localparam logic [WCNT_W-1:0] WCNT_MAX = '1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_THRESH = 2'd0,
    REG_WINDOW = 2'd1,
    REG_MLIMIT = 2'd2,
    REG_SLIMIT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    IR_OFF   = 2'd0,
    IR_ON    = 2'd1,
    IR_PULSE = 2'd2
  } ir_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DSTART,
    ST_DWAIT,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/amic_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module amic_div import amic_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [AVG_W-1:0] quot_o
);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [AVG_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // quotient fits in AVG_W bits, so the upper dividend bits start below the divisor
  assign trial = {rem_q, quo_q[AVG_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = CNT_W'(dividend_i[SUM_W-1:AVG_W]);
      quo_d  = dividend_i[AVG_W-1:0];
      step_d = STEP_W'(AVG_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d  = {quo_q[AVG_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

@@ hdl/accel_motion_ir_control.sv @@
// top level of the motion driven ir led mode controller
`timescale 1ns / 1ps

// usage
// - input channel: one accelerometer item (x, y, z, ircut_open) per handshake,
//   accepted when in_valid_i is high and in_stall_o is low
// - items with ircut_open low are accepted without a stall and leave no trace
// - the first used item only primes the previous sample; later items add the
//   absolute per-axis change to the window sums
// - an ordinary item keeps in_stall_o high in the ST_ACC state after acceptance
// - the item that closes a window runs three serial divisions through one
//   shared restoring divider, one axis after the other, then the motion
//   decision, which waits for a free output register; in_stall_o stays high
//   from acceptance until out_valid_o rises
// - output channel: one result item per closed window, held in an output
//   register until taken; a new sample may be accepted while it waits, and
//   only a further window close waits for the output register to free up
// - apb port writes the movement threshold, the window length and both window
//   limits at byte addresses 0, 4, 8, 12; reads return the register values
// - reset restores the register defaults, clears all sums and counters and
//   sets the ir mode to on

module accel_motion_ir_control import amic_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] accel_x_i,
  input  logic signed [SAMPLE_W-1:0] accel_y_i,
  input  logic signed [SAMPLE_W-1:0] accel_z_i,
  input  logic                       ircut_open_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [15:0]                avg_change_x_o,
  output logic [15:0]                avg_change_y_o,
  output logic [15:0]                avg_change_z_o,
  output logic                       compared_o,
  output logic                       motion_seen_o,
  output logic [1:0]                 ir_mode_o,
  output logic                       ir_changed_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  // absolute difference of two signed samples
  function automatic logic [SAMPLE_W-1:0] abs_diff(logic signed [SAMPLE_W-1:0] a,
                                                   logic signed [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] ae;
    logic signed [SAMPLE_W:0] be;
    logic signed [SAMPLE_W:0] d;
    ae = {a[SAMPLE_W-1], a};
    be = {b[SAMPLE_W-1], b};
    d  = (ae > be) ? ae - be : be - ae;
    return d[SAMPLE_W-1:0];
  endfunction

  // true when two averages differ by more than the threshold
  function automatic logic moved(logic [AVG_W-1:0] a, logic [AVG_W-1:0] b,
                                 logic [THR_W-1:0] thr);
    logic [AVG_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return 32'(d) > 32'(thr);
  endfunction

  // clip a full width average to the 16 bit output
  function automatic logic [15:0] sat16(logic [AVG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  // configuration registers
  logic [THR_W-1:0] thr_q;
  logic [WIN_W-1:0] win_q;
  logic [LIM_W-1:0] mlimit_q;
  logic [LIM_W-1:0] slimit_q;
  logic             cfg_wr;

  // window state
  state_e                     state_q, state_d;
  logic signed [SAMPLE_W-1:0] smp_x_q, smp_y_q, smp_z_q;
  logic signed [SAMPLE_W-1:0] last_x_q, last_y_q, last_z_q;
  logic                       primed_q;
  logic [SUM_W-1:0]           sum_x_q, sum_y_q, sum_z_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [CNT_W-1:0]           cnt_inc;
  logic [CNT_W-1:0]           win_eff;
  logic                       win_close;
  logic [AVG_W-1:0]           avg_x_q, avg_y_q, avg_z_q;
  logic [AVG_W-1:0]           old_x_q, old_y_q, old_z_q;
  logic                       have_old_q;
  logic [WCNT_W-1:0]          mw_q, sw_q;
  ir_mode_e                   led_q;
  logic [1:0]                 axis_q;

  // divider hookup
  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  div_stat_t        div_stat;
  logic [AVG_W-1:0] div_quot;

  // decision
  logic              motion;
  logic [WCNT_W-1:0] mw_n, sw_n;
  ir_mode_e          led_n;
  logic              slot_free;
  logic              commit;

  // result register
  logic       out_valid_q;
  logic [15:0] out_x_q, out_y_q, out_z_q;
  logic       out_cmp_q, out_mot_q, out_chg_q;
  ir_mode_e   out_mode_q;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RST;
      win_q    <= WIN_RST;
      mlimit_q <= MLIMIT_RST;
      slimit_q <= SLIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_THRESH: thr_q    <= pwdata[THR_W-1:0];
        REG_WINDOW: win_q    <= pwdata[WIN_W-1:0];
        REG_MLIMIT: mlimit_q <= pwdata[LIM_W-1:0];
        REG_SLIMIT: slimit_q <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_THRESH: prdata = DATA_W'(thr_q);
      REG_WINDOW: prdata = DATA_W'(win_q);
      REG_MLIMIT: prdata = DATA_W'(mlimit_q);
      REG_SLIMIT: prdata = DATA_W'(slimit_q);
      default:    prdata = '0;
    endcase
  end

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    if (win_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(win_q);
    end
  end

  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign win_close = cnt_inc >= win_eff;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ircut_open_i) state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = (primed_q && win_close) ? ST_DSTART : ST_IDLE;
      end
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_stat.done) state_d = (axis_q == 2'd2) ? ST_DECIDE : ST_DSTART;
      end
      ST_DECIDE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_DSTART: div_start  = 1'b1;
      ST_DECIDE: commit     = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // shared divider, one axis after the other
  // ---------------------------------------------------------------------------
  always_comb begin
    case (axis_q)
      2'd0:    div_dividend = sum_x_q;
      2'd1:    div_dividend = sum_y_q;
      default: div_dividend = sum_z_q;
    endcase
  end

  amic_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // ---------------------------------------------------------------------------
  // motion decision and led mode
  // ---------------------------------------------------------------------------
  assign motion = have_old_q && (moved(avg_x_q, old_x_q, thr_q) ||
                                 moved(avg_y_q, old_y_q, thr_q) ||
                                 moved(avg_z_q, old_z_q, thr_q));

  always_comb begin
    mw_n  = mw_q;
    sw_n  = sw_q;
    led_n = led_q;
    if (have_old_q) begin
      if (motion) begin
        if (mw_q != WCNT_MAX) mw_n = mw_q + WCNT_W'(1);
        if (mw_n > mlimit_q) begin
          sw_n  = '0;
          led_n = IR_ON;
        end
      end else begin
        if (sw_q != WCNT_MAX) sw_n = sw_q + WCNT_W'(1);
        mw_n = '0;
      end
    end
    // still rule applies at every window, first one included
    if (sw_n > slimit_q) begin
      led_n = (led_n == IR_PULSE) ? IR_OFF : IR_PULSE;
      sw_n  = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      smp_x_q <= accel_x_i;
      smp_y_q <= accel_y_i;
      smp_z_q <= accel_z_i;
    end
    if (state_q == ST_DWAIT && div_stat.done) begin
      case (axis_q)
        2'd0:    avg_x_q <= div_quot;
        2'd1:    avg_y_q <= div_quot;
        default: avg_z_q <= div_quot;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q   <= '0;
      last_y_q   <= '0;
      last_z_q   <= '0;
      primed_q   <= 1'b0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_z_q    <= '0;
      cnt_q      <= '0;
      old_x_q    <= '0;
      old_y_q    <= '0;
      old_z_q    <= '0;
      have_old_q <= 1'b0;
      mw_q       <= '0;
      sw_q       <= '0;
      led_q      <= IR_ON;
      axis_q     <= '0;
    end else begin
      if (state_q == ST_ACC) begin
        last_x_q <= smp_x_q;
        last_y_q <= smp_y_q;
        last_z_q <= smp_z_q;
        primed_q <= 1'b1;
        axis_q   <= '0;
        if (primed_q) begin
          sum_x_q <= sum_x_q + SUM_W'(abs_diff(smp_x_q, last_x_q));
          sum_y_q <= sum_y_q + SUM_W'(abs_diff(smp_y_q, last_y_q));
          sum_z_q <= sum_z_q + SUM_W'(abs_diff(smp_z_q, last_z_q));
          cnt_q   <= cnt_inc;
        end
      end
      if (state_q == ST_DWAIT && div_stat.done) begin
        axis_q <= axis_q + 2'd1;
      end
      if (commit) begin
        old_x_q    <= avg_x_q;
        old_y_q    <= avg_y_q;
        old_z_q    <= avg_z_q;
        have_old_q <= 1'b1;
        mw_q       <= mw_n;
        sw_q       <= sw_n;
        led_q      <= led_n;
        sum_x_q    <= '0;
        sum_y_q    <= '0;
        sum_z_q    <= '0;
        cnt_q      <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_x_q    <= sat16(avg_x_q);
      out_y_q    <= sat16(avg_y_q);
      out_z_q    <= sat16(avg_z_q);
      out_cmp_q  <= have_old_q;
      out_mot_q  <= motion;
      out_mode_q <= led_n;
      out_chg_q  <= led_n != led_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign avg_change_x_o = out_x_q;
  assign avg_change_y_o = out_y_q;
  assign avg_change_z_o = out_z_q;
  assign compared_o     = out_cmp_q;
  assign motion_seen_o  = out_mot_q;
  assign ir_mode_o      = out_mode_q;
  assign ir_changed_o   = out_chg_q;

endmodule

@@ tb/amic_window_checker.sv @@
`timescale 1ns / 1ps
// checker that predicts the window reports of the motion driven ir controller and compares them

module amic_window_checker import amic_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [SAMPLE_W-1:0] accel_x_i,
  input  logic signed [SAMPLE_W-1:0] accel_y_i,
  input  logic signed [SAMPLE_W-1:0] accel_z_i,
  input  logic                       ircut_open_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [15:0]                avg_change_x_i,
  input  logic [15:0]                avg_change_y_i,
  input  logic [15:0]                avg_change_z_i,
  input  logic                       compared_i,
  input  logic                       motion_seen_i,
  input  logic [1:0]                 ir_mode_i,
  input  logic                       ir_changed_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [ADDR_W-1:0]          paddr_i,
  input  logic [DATA_W-1:0]          pwdata_i,
  input  logic [DATA_W-1:0]          prdata_i,
  input  logic                       pready_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         windows_o,
  output int                         motion_o,
  output int                         changes_o
);

  typedef struct packed {
    logic [AVG_W-1:0] avg_x;
    logic [AVG_W-1:0] avg_y;
    logic [AVG_W-1:0] avg_z;
    logic             compared;
    logic             motion;
    ir_mode_e         mode;
    logic             changed;
  } window_report_t;

  // register copies
  logic [THR_W-1:0] thresh;
  logic [WIN_W-1:0] win_len;
  logic [LIM_W-1:0] motion_lim;
  logic [LIM_W-1:0] still_lim;

  // predictor state
  logic signed [SAMPLE_W-1:0] prev_x, prev_y, prev_z;
  logic                       primed;
  logic [SUM_W-1:0]           sum_x, sum_y, sum_z;
  logic [CNT_W-1:0]           count;
  logic [AVG_W-1:0]           base_x, base_y, base_z;
  logic                       have_base;
  logic [WCNT_W-1:0]          motion_run, still_run;
  ir_mode_e                   mode;

  window_report_t window_reports[$];
  window_report_t due;

  function automatic int unsigned abs_delta(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(reg_idx_e r);
    case (r)
      REG_THRESH: return DATA_W'(thresh);
      REG_WINDOW: return DATA_W'(win_len);
      REG_MLIMIT: return DATA_W'(motion_lim);
      default:    return DATA_W'(still_lim);
    endcase
  endfunction

  function automatic void take_sample(logic signed [SAMPLE_W-1:0] x,
                                      logic signed [SAMPLE_W-1:0] y,
                                      logic signed [SAMPLE_W-1:0] z);
    int unsigned    span;
    logic [AVG_W-1:0] ax, ay, az;
    ir_mode_e       mode_was;
    window_report_t rep;
    if (!primed) begin
      prev_x = x;
      prev_y = y;
      prev_z = z;
      primed = 1'b1;
      return;
    end
    sum_x += SUM_W'(abs_delta(x, prev_x));
    sum_y += SUM_W'(abs_delta(y, prev_y));
    sum_z += SUM_W'(abs_delta(z, prev_z));
    prev_x = x;
    prev_y = y;
    prev_z = z;
    count++;
    // window length is clamped to 1..MAX_WINDOW
    span = win_len;
    if (span < 1) span = 1;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    if (count < span) return;

    ax = AVG_W'(sum_x / count);
    ay = AVG_W'(sum_y / count);
    az = AVG_W'(sum_z / count);
    mode_was = mode;
    rep.compared = have_base;
    rep.motion = 1'b0;
    if (have_base) begin
      if (abs_delta(ax, base_x) > thresh || abs_delta(ay, base_y) > thresh ||
          abs_delta(az, base_z) > thresh) begin
        rep.motion = 1'b1;
        if (motion_run != WCNT_MAX) motion_run++;
        if (motion_run > motion_lim) begin
          still_run = '0;
          mode = IR_ON;
        end
      end else begin
        if (still_run != WCNT_MAX) still_run++;
        motion_run = '0;
      end
    end
    base_x = ax;
    base_y = ay;
    base_z = az;
    have_base = 1'b1;
    // still rule runs on every window, first one included
    if (still_run > still_lim) begin
      mode = (mode == IR_PULSE) ? IR_OFF : IR_PULSE;
      still_run = '0;
    end
    sum_x = '0;
    sum_y = '0;
    sum_z = '0;
    count = '0;

    rep.avg_x = ax;
    rep.avg_y = ay;
    rep.avg_z = az;
    rep.mode = mode;
    rep.changed = (mode != mode_was);
    window_reports.push_back(rep);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh = THR_RST;
      win_len = WIN_RST;
      motion_lim = MLIMIT_RST;
      still_lim = SLIMIT_RST;
      prev_x = '0;
      prev_y = '0;
      prev_z = '0;
      primed = 1'b0;
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      count = '0;
      base_x = '0;
      base_y = '0;
      base_z = '0;
      have_base = 1'b0;
      motion_run = '0;
      still_run = '0;
      mode = IR_ON;
      window_reports.delete();
      fail_count_o = 0;
      pending_o = 0;
      windows_o = 0;
      motion_o = 0;
      changes_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (reg_idx_e'(paddr_i[3:2]))
            REG_THRESH: thresh = pwdata_i[THR_W-1:0];
            REG_WINDOW: win_len = pwdata_i[WIN_W-1:0];
            REG_MLIMIT: motion_lim = pwdata_i[LIM_W-1:0];
            default:    still_lim = pwdata_i[LIM_W-1:0];
          endcase
        end else begin
          check_field("prdata", reg_value(reg_idx_e'(paddr_i[3:2])), prdata_i);
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (window_reports.size() == 0) begin
          $error("result item with no window report pending");
          fail_count_o++;
        end else begin
          due = window_reports.pop_front();
          check_field("avg_change_x", due.avg_x, avg_change_x_i);
          check_field("avg_change_y", due.avg_y, avg_change_y_i);
          check_field("avg_change_z", due.avg_z, avg_change_z_i);
          check_field("compared", due.compared, compared_i);
          check_field("motion_seen", due.motion, motion_seen_i);
          check_field("ir_mode", due.mode, ir_mode_i);
          check_field("ir_changed", due.changed, ir_changed_i);
          windows_o++;
          if (due.motion) motion_o++;
          if (due.changed) changes_o++;
        end
      end

      // filter closed: item leaves no trace
      if (in_valid_i && !in_stall_i && ircut_open_i)
        take_sample(accel_x_i, accel_y_i, accel_z_i);

      pending_o = window_reports.size();
    end
  end

endmodule

@@ tb/accel_motion_ir_control_test.sv @@
`timescale 1ns / 1ps
// top of the testbench for the motion driven ir controller: stimulus and verdict

module accel_motion_ir_control_test;
  import amic_pkg::*;

  // clock period 8 ns; generous cycle budget for the whole run
  localparam int CYCLE_LIMIT   = 500000;
  // allow margin for a window close to finish before touching registers
  localparam int SETTLE_CYCLES = 80;
  localparam int TAIL_CYCLES   = 100;
  // long receiver hold-off, enough to back the block up onto its input
  localparam int HOLD_CYCLES   = 300;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] accel_x_i;
  logic signed [SAMPLE_W-1:0] accel_y_i;
  logic signed [SAMPLE_W-1:0] accel_z_i;
  logic                       ircut_open_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [15:0]                avg_change_x_o;
  logic [15:0]                avg_change_y_o;
  logic [15:0]                avg_change_z_o;
  logic                       compared_o;
  logic                       motion_seen_o;
  logic [1:0]                 ir_mode_o;
  logic                       ir_changed_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  int fail_count, pending, windows, motion_windows, mode_changes;

  // idling percentages, changed by the stimulus between phases
  int tx_idle_pct;
  int rx_stall_pct;
  // request for a long receiver hold-off, cleared by the receiver
  logic hold_req;
  int   hold_left;
  int   items_sent;
  int   cycles;

  accel_motion_ir_control u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .ircut_open_i   (ircut_open_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .avg_change_x_o (avg_change_x_o),
    .avg_change_y_o (avg_change_y_o),
    .avg_change_z_o (avg_change_z_o),
    .compared_o     (compared_o),
    .motion_seen_o  (motion_seen_o),
    .ir_mode_o      (ir_mode_o),
    .ir_changed_o   (ir_changed_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // watches both channels and the register port, predicts and compares
  amic_window_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .ircut_open_i   (ircut_open_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .avg_change_x_i (avg_change_x_o),
    .avg_change_y_i (avg_change_y_o),
    .avg_change_z_i (avg_change_z_o),
    .compared_i     (compared_o),
    .motion_seen_i  (motion_seen_o),
    .ir_mode_i      (ir_mode_o),
    .ir_changed_i   (ir_changed_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .windows_o      (windows),
    .motion_o       (motion_windows),
    .changes_o      (mode_changes)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit, counted in clock cycles
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** accel_motion_ir_control: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked for one
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // one item on the sample channel: optional idle gap, then hold until taken
  task automatic push_item(input logic signed [SAMPLE_W-1:0] x,
                           input logic signed [SAMPLE_W-1:0] y,
                           input logic signed [SAMPLE_W-1:0] z,
                           input logic                       open);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    accel_x_i    <= x;
    accel_y_i    <= y;
    accel_z_i    <= z;
    ircut_open_i <= open;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  // drop valid, wait for every expected window report, then let the block go idle
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // apb setup then access phase; the checker mirrors writes and checks reads
  task automatic apb_access(input reg_idx_e r, input logic wr, input logic [DATA_W-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_regs();
    for (int r = 0; r < 4; r++) apb_access(reg_idx_e'(r), 1'b0, '0);
  endtask

  // amplitude of sample noise: from dead still up to full scale
  function automatic int spread_pick();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 3;
      2:       return 40;
      3:       return 600;
      4:       return 5000;
      default: return 65535;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] axis_sample(int centre, int spread);
    int v;
    if (spread >= 65535) return SAMPLE_W'($urandom);
    v = centre + int'($urandom_range(0, spread)) - spread / 2;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  // one phase: registers written while idle, then well formed sample runs whose
  // noise level wanders, unless spread_fix pins it, so both motion and still
  // windows turn up; a few items with the filter closed are mixed in as noise
  task automatic run_phase(input int thr, input int win, input int mlim, input int slim,
                           input int n, input int spread_fix, input int hold_at);
    int spread;
    int centre;
    settle_idle();
    apb_access(REG_THRESH, 1'b1, thr);
    apb_access(REG_WINDOW, 1'b1, win);
    apb_access(REG_MLIMIT, 1'b1, mlim);
    apb_access(REG_SLIMIT, 1'b1, slim);
    read_all_regs();
    centre = int'($urandom_range(0, 16000)) - 8000;
    spread = (spread_fix >= 0) ? spread_fix : spread_pick();
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (spread_fix < 0 && $urandom_range(0, 15) == 0) spread = spread_pick();
      if ($urandom_range(0, 99) < 8)
        push_item(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b0);
      else
        push_item(axis_sample(centre, spread), axis_sample(centre, spread),
                  axis_sample(centre, spread), 1'b1);
    end
  endtask

  // short windows with random threshold and limits
  task automatic random_phase(input int n);
    int thr;
    thr = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 64) : $urandom_range(100, 3000);
    run_phase(thr, $urandom_range(1, 6), $urandom_range(0, 3), $urandom_range(0, 4),
              n, -1, -1);
  endtask

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    accel_x_i    = '0;
    accel_y_i    = '0;
    accel_z_i    = '0;
    ircut_open_i = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_req     = 1'b0;
    items_sent   = 0;
    // sender idles lightly, receiver heavily
    tx_idle_pct  = 21;
    rx_stall_pct = 53;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // register values straight out of reset
    read_all_regs();

    // directed: window length 0 acts as 1, both limits at zero
    apb_access(REG_THRESH, 1'b1, 410);
    apb_access(REG_WINDOW, 1'b1, 0);
    apb_access(REG_MLIMIT, 1'b1, 0);
    apb_access(REG_SLIMIT, 1'b1, 0);
    push_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);     // filter closed, ignored
    push_item(-16'sd32768, 16'sd32767, 16'sd0, 1'b1);      // priming sample
    push_item(16'sd32767, -16'sd32768, 16'sd0, 1'b1);      // first window, full swing
    push_item(16'sd32767, -16'sd32768, 16'sd0, 1'b1);      // motion, ir on
    push_item(16'sd32767, -16'sd32768, 16'sd0, 1'b1);      // still, on to pulse
    push_item(16'sd32767, -16'sd32768, 16'sd0, 1'b1);      // still, pulse to off
    push_item(-16'sd32768, 16'sd32767, -16'sd32768, 1'b1); // motion, back on
    push_item(-16'sd1, 16'sd1, 16'sd0, 1'b0);              // closed again
    push_item(-16'sd1, 16'sd1, 16'sd0, 1'b1);

    // window length lowered part way through a window
    settle_idle();
    apb_access(REG_WINDOW, 1'b1, 8);
    push_item(16'sd100, -16'sd200, 16'sd300, 1'b1);
    push_item(-16'sd100, 16'sd200, -16'sd300, 1'b1);
    push_item(16'sd5, 16'sd7, 16'sd9, 1'b1);
    settle_idle();
    apb_access(REG_WINDOW, 1'b1, 2);
    push_item(16'sd1000, 16'sd1000, 16'sd1000, 1'b1);      // closes with four samples

    // window register above the maximum: no early close, then lowered part way
    settle_idle();
    apb_access(REG_WINDOW, 1'b1, 2047);
    read_all_regs();
    push_item(16'sd10, 16'sd20, 16'sd30, 1'b1);
    push_item(-16'sd10, -16'sd20, -16'sd30, 1'b1);
    push_item(16'sd400, 16'sd0, -16'sd400, 1'b1);
    push_item(16'sd0, 16'sd0, 16'sd0, 1'b1);
    settle_idle();
    apb_access(REG_WINDOW, 1'b1, 3);
    push_item(16'sd50, 16'sd60, 16'sd70, 1'b1);            // closes with five samples

    // zero threshold, single sample windows; long receiver hold-off part way
    run_phase(0, 1, 0, 0, 80, -1, 20);
    // nothing ever counts as motion, still count runs into saturation
    run_phase(65535, 1, 255, 255, 300, -1, -1);
    // full scale noise, motion count runs into saturation
    run_phase(0, 1, 255, 2, 300, 65535, -1);

    // sender idles heavily, receiver lightly
    tx_idle_pct  = 53;
    rx_stall_pct = 21;
    for (int k = 0; k < 2; k++) random_phase(90);
    // longer windows with low limits
    run_phase(200, 24, 1, 1, 150, -1, -1);

    // no idling on either side
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int k = 0; k < 2; k++) random_phase(90);
    run_phase(410, 4, 5, 6, 100, -1, -1);

    settle_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("%0d samples offered; windows of 1 to 24 samples and an oversized window,",
             items_sent);
    $display("limits 0 to 255; %0d window reports checked, %0d motion, %0d ir mode changes",
             windows, motion_windows, mode_changes);
    if (fail_count == 0)
      $display("** accel_motion_ir_control: PASSED **");
    else
      $display("** accel_motion_ir_control: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/amic_pkg.sv
hdl/amic_div.sv
hdl/accel_motion_ir_control.sv
tb/amic_window_checker.sv
tb/accel_motion_ir_control_test.sv
